@@ hw/rtl/bmmhq_pkg.sv @@
`timescale 1ns / 1ps
package bmmhq_pkg;

    localparam int DEPTH  = 256;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int PRIO_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;
    localparam logic             OP_PUSH   = 1'b0;
    localparam logic             OP_POP    = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [IDX_W-1:0]  hdl;
    } entry_t;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_REJECT  = 2'd1,
        ST_REMOVED = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        entry_t            wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  hdl;
        logic              ev;
        logic [PRIO_W-1:0] evp;
        logic [IDX_W-1:0]  evh;
        logic [CNT_W-1:0]  cnt;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE, S_ROOT, S_POS, S_LAST, S_APP_RD, S_WR1, S_WR2, S_SCAN,
        S_SD_START, S_SD_CHILD, S_SD_GCHK, S_SD_GRAND, S_SD_EXIT,
        S_SU_START, S_SU_X, S_SU_P, S_SU_G, S_SU_GC, S_DONE
    } state_t;

    // min level ordering when inv is 0, max level ordering when inv is 1
    function automatic logic before_f(logic [PRIO_W-1:0] a, logic [PRIO_W-1:0] b,
                                      logic inv);
        return (a < b) != inv;
    endfunction

    function automatic logic max_level_f(logic [IDX_W-1:0] i);
        logic [IDX_W:0] n;
        logic           lvl;
        n   = {1'b0, i} + {{IDX_W{1'b0}}, 1'b1};
        lvl = 1'b0;
        for (int b = 0; b <= IDX_W; b++) begin
            if (n[b]) lvl = b[0];
        end
        return lvl;
    endfunction

endpackage

@@ hw/rtl/bmmhq_mem.sv @@
`timescale 1ns / 1ps
module bmmhq_mem (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmmhq_pkg::mem_req_t  req,
    output bmmhq_pkg::entry_t    rd
);

    bmmhq_pkg::entry_t                      mem [bmmhq_pkg::DEPTH];
    logic [bmmhq_pkg::DEPTH-1:0]            vld_reg;
    bmmhq_pkg::entry_t                      rd_reg;
    logic                                   rvld_reg;
    logic [bmmhq_pkg::IDX_W-1:0]            raddr_reg;

    always_ff @(posedge aclk) begin
        if (req.we) mem[req.waddr] <= req.wdata;
        rd_reg    <= mem[req.raddr];
        raddr_reg <= req.raddr;
    end

    // unwritten handle entries read as their own position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            rvld_reg <= vld_reg[req.raddr];
            if (req.we) vld_reg[req.waddr] <= 1'b1;
        end
    end

    always_comb begin
        rd.prio = rd_reg.prio;
        rd.hdl  = rvld_reg ? rd_reg.hdl : raddr_reg;
    end

endmodule

@@ hw/rtl/bmmhq_ctrl.sv @@
`timescale 1ns / 1ps
module bmmhq_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    input  logic [bmmhq_pkg::PRIO_W-1:0]        in_prio,
    input  logic [bmmhq_pkg::IDX_W-1:0]         in_pos,
    input  logic [bmmhq_pkg::CNT_W-1:0]         cap,
    input  bmmhq_pkg::entry_t                   rd,
    output bmmhq_pkg::mem_req_t                 mem_req,
    input  logic                                out_free,
    output logic                                done,
    output bmmhq_pkg::result_t                  result
);

    bmmhq_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [8:0]  count_reg, count_next;
    logic        op_reg, op_next, inv_reg, inv_next;
    logic [31:0] prio_reg, prio_next;
    logic [7:0]  pos_reg, pos_next, i_reg, i_next, bidx_reg, bidx_next;
    logic [7:0]  base_reg, base_next, wa1_reg, wa1_next, wa2_reg, wa2_next;
    logic [2:0]  n_reg, n_next, k_reg, k_next;
    bmmhq_pkg::entry_t cur_reg, cur_next, rem_reg, rem_next, best_reg, best_next;
    bmmhq_pkg::entry_t wd1_reg, wd1_next, wd2_reg, wd2_next;
    bmmhq_pkg::status_t status_reg, status_next;
    logic [7:0]  hdl_reg, hdl_next, evh_reg, evh_next;
    logic        ev_reg, ev_next;
    logic [31:0] evp_reg, evp_next;

    logic [8:0]  cap_eff, count_m1;
    logic [10:0] cnt11, lc, lg, dc, dg;
    logic [8:0]  par9, gp9;
    logic [7:0]  par, gpm1;
    logic        better;

    always_comb begin
        cap_eff  = (cap == 9'd0) ? 9'd1 : ((cap > 9'd256) ? 9'd256 : cap);
        count_m1 = count_reg - 9'd1;
        cnt11    = {2'b00, count_reg};
        lc       = {2'b00, i_reg, 1'b1};
        lg       = {1'b0, i_reg, 2'b11};
        dc       = cnt11 - lc;
        dg       = cnt11 - lg;
        par9     = (({1'b0, i_reg} + 9'd1) >> 1) - 9'd1;
        par      = par9[7:0];
        gp9      = ({1'b0, i_reg} + 9'd1) >> 2;
        gpm1     = gp9[7:0] - 8'd1;
        better   = bmmhq_pkg::before_f(best_reg.prio, cur_reg.prio, inv_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bmmhq_pkg::S_IDLE: begin
                if (in_valid) begin
                    if (in_op == bmmhq_pkg::OP_PUSH)
                        state_next = (count_reg >= cap_eff) ? bmmhq_pkg::S_ROOT
                                                            : bmmhq_pkg::S_APP_RD;
                    else
                        state_next = ({1'b0, in_pos} >= count_reg) ? bmmhq_pkg::S_DONE
                                                                   : bmmhq_pkg::S_POS;
                end
            end
            bmmhq_pkg::S_ROOT:
                state_next = (prio_reg < rd.prio) ? bmmhq_pkg::S_DONE : bmmhq_pkg::S_LAST;
            bmmhq_pkg::S_POS:    state_next = bmmhq_pkg::S_LAST;
            bmmhq_pkg::S_LAST:   state_next = bmmhq_pkg::S_WR1;
            bmmhq_pkg::S_APP_RD: state_next = bmmhq_pkg::S_WR1;
            bmmhq_pkg::S_WR1:    state_next = bmmhq_pkg::S_WR2;
            bmmhq_pkg::S_WR2:    state_next = ret_reg;
            bmmhq_pkg::S_SCAN:   if (k_reg == n_reg) state_next = ret_reg;
            bmmhq_pkg::S_SD_START:
                state_next = (lc >= cnt11) ? bmmhq_pkg::S_SD_EXIT : bmmhq_pkg::S_SCAN;
            bmmhq_pkg::S_SD_CHILD:
                state_next = better ? bmmhq_pkg::S_WR1 : bmmhq_pkg::S_SD_GCHK;
            bmmhq_pkg::S_SD_GCHK:
                state_next = (lg >= cnt11) ? bmmhq_pkg::S_SD_EXIT : bmmhq_pkg::S_SCAN;
            bmmhq_pkg::S_SD_GRAND:
                state_next = better ? bmmhq_pkg::S_WR1 : bmmhq_pkg::S_SD_EXIT;
            bmmhq_pkg::S_SD_EXIT:
                state_next = (op_reg == bmmhq_pkg::OP_PUSH) ? bmmhq_pkg::S_WR1
                                                            : bmmhq_pkg::S_SU_START;
            bmmhq_pkg::S_SU_START: state_next = bmmhq_pkg::S_SU_X;
            bmmhq_pkg::S_SU_X:
                state_next = (i_reg != 8'd0) ? bmmhq_pkg::S_SU_P : bmmhq_pkg::S_SU_G;
            bmmhq_pkg::S_SU_P:
                state_next = ((cur_reg.prio > rd.prio) != inv_reg) ? bmmhq_pkg::S_WR1
                                                                   : bmmhq_pkg::S_SU_G;
            bmmhq_pkg::S_SU_G:
                state_next = (gp9 != 9'd0) ? bmmhq_pkg::S_SU_GC : bmmhq_pkg::S_DONE;
            bmmhq_pkg::S_SU_GC:
                state_next = bmmhq_pkg::before_f(cur_reg.prio, rd.prio, inv_reg)
                             ? bmmhq_pkg::S_WR1 : bmmhq_pkg::S_DONE;
            bmmhq_pkg::S_DONE:   if (out_free) state_next = bmmhq_pkg::S_IDLE;
            default:             state_next = bmmhq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ret_next    = ret_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        inv_next    = inv_reg;
        prio_next   = prio_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        bidx_next   = bidx_reg;
        base_next   = base_reg;
        wa1_next    = wa1_reg;
        wa2_next    = wa2_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        best_next   = best_reg;
        wd1_next    = wd1_reg;
        wd2_next    = wd2_reg;
        status_next = status_reg;
        hdl_next    = hdl_reg;
        ev_next     = ev_reg;
        evp_next    = evp_reg;
        evh_next    = evh_reg;
        mem_req     = '0;
        in_ready    = 1'b0;
        done        = 1'b0;
        case (state_reg)
            bmmhq_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    prio_next   = in_prio;
                    pos_next    = in_pos;
                    hdl_next    = 8'd0;
                    ev_next     = 1'b0;
                    evp_next    = 32'd0;
                    evh_next    = 8'd0;
                    status_next = bmmhq_pkg::ST_INVALID;
                    if (in_op == bmmhq_pkg::OP_PUSH)
                        mem_req.raddr = (count_reg >= cap_eff) ? 8'd0 : count_reg[7:0];
                    else
                        mem_req.raddr = in_pos;
                end
            end
            bmmhq_pkg::S_ROOT: begin
                if (prio_reg < rd.prio) begin
                    status_next = bmmhq_pkg::ST_REJECT;
                end else begin
                    ev_next       = 1'b1;
                    evp_next      = rd.prio;
                    evh_next      = rd.hdl;
                    rem_next      = rd;
                    pos_next      = 8'd0;
                    mem_req.raddr = count_m1[7:0];
                end
            end
            bmmhq_pkg::S_POS: begin
                rem_next      = rd;
                hdl_next      = rd.hdl;
                mem_req.raddr = count_m1[7:0];
            end
            bmmhq_pkg::S_LAST: begin
                // move the last entry into the hole, removed entry to the tail
                wa1_next   = pos_reg;
                wd1_next   = rd;
                wa2_next   = count_m1[7:0];
                wd2_next   = rem_reg;
                count_next = count_m1;
                cur_next   = rd;
                i_next     = pos_reg;
                if (op_reg == bmmhq_pkg::OP_PUSH) begin
                    inv_next = 1'b0;
                    ret_next = bmmhq_pkg::S_SD_START;
                end else begin
                    inv_next    = bmmhq_pkg::max_level_f(pos_reg);
                    status_next = bmmhq_pkg::ST_REMOVED;
                    ret_next    = ({1'b0, pos_reg} < count_m1) ? bmmhq_pkg::S_SD_START
                                                               : bmmhq_pkg::S_DONE;
                end
            end
            bmmhq_pkg::S_APP_RD: begin
                status_next = bmmhq_pkg::ST_ADDED;
                hdl_next    = rd.hdl;
                wa1_next    = count_reg[7:0];
                wa2_next    = count_reg[7:0];
                wd1_next    = '{prio: prio_reg, hdl: rd.hdl};
                wd2_next    = '{prio: prio_reg, hdl: rd.hdl};
                i_next      = count_reg[7:0];
                count_next  = count_reg + 9'd1;
                ret_next    = bmmhq_pkg::S_SU_START;
            end
            bmmhq_pkg::S_WR1: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wa1_reg;
                mem_req.wdata = wd1_reg;
            end
            bmmhq_pkg::S_WR2: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wa2_reg;
                mem_req.wdata = wd2_reg;
            end
            bmmhq_pkg::S_SCAN: begin
                // issue one read a cycle, fold the previous one into best
                mem_req.raddr = base_reg + {5'd0, k_reg};
                if (k_reg != 3'd0) begin
                    if (k_reg == 3'd1 ||
                        bmmhq_pkg::before_f(rd.prio, best_reg.prio, inv_reg)) begin
                        best_next = rd;
                        bidx_next = base_reg + {5'd0, k_reg} - 8'd1;
                    end
                end
                k_next = k_reg + 3'd1;
            end
            bmmhq_pkg::S_SD_START: begin
                base_next = lc[7:0];
                n_next    = (dc >= 11'd2) ? 3'd2 : dc[2:0];
                k_next    = 3'd0;
                ret_next  = bmmhq_pkg::S_SD_CHILD;
            end
            bmmhq_pkg::S_SD_CHILD: begin
                if (better) begin
                    wa1_next = i_reg;
                    wd1_next = best_reg;
                    wa2_next = bidx_reg;
                    wd2_next = cur_reg;
                    cur_next = best_reg;
                    ret_next = bmmhq_pkg::S_SD_GCHK;
                end
            end
            bmmhq_pkg::S_SD_GCHK: begin
                base_next = lg[7:0];
                n_next    = (dg >= 11'd4) ? 3'd4 : dg[2:0];
                k_next    = 3'd0;
                ret_next  = bmmhq_pkg::S_SD_GRAND;
            end
            bmmhq_pkg::S_SD_GRAND: begin
                if (better) begin
                    wa1_next = i_reg;
                    wd1_next = best_reg;
                    wa2_next = bidx_reg;
                    wd2_next = cur_reg;
                    i_next   = bidx_reg;
                    ret_next = bmmhq_pkg::S_SD_START;
                end
            end
            bmmhq_pkg::S_SD_EXIT: begin
                if (op_reg == bmmhq_pkg::OP_PUSH) begin
                    status_next = bmmhq_pkg::ST_ADDED;
                    hdl_next    = evh_reg;
                    wa1_next    = count_reg[7:0];
                    wa2_next    = count_reg[7:0];
                    wd1_next    = '{prio: prio_reg, hdl: evh_reg};
                    wd2_next    = '{prio: prio_reg, hdl: evh_reg};
                    i_next      = count_reg[7:0];
                    count_next  = count_reg + 9'd1;
                    ret_next    = bmmhq_pkg::S_SU_START;
                end else begin
                    i_next = pos_reg;
                end
            end
            bmmhq_pkg::S_SU_START: begin
                mem_req.raddr = i_reg;
            end
            bmmhq_pkg::S_SU_X: begin
                cur_next      = rd;
                inv_next      = bmmhq_pkg::max_level_f(i_reg);
                mem_req.raddr = par;
            end
            bmmhq_pkg::S_SU_P: begin
                if ((cur_reg.prio > rd.prio) != inv_reg) begin
                    wa1_next = i_reg;
                    wd1_next = rd;
                    wa2_next = par;
                    wd2_next = cur_reg;
                    i_next   = par;
                    inv_next = !inv_reg;
                    ret_next = bmmhq_pkg::S_SU_G;
                end
            end
            bmmhq_pkg::S_SU_G: begin
                mem_req.raddr = gpm1;
            end
            bmmhq_pkg::S_SU_GC: begin
                if (bmmhq_pkg::before_f(cur_reg.prio, rd.prio, inv_reg)) begin
                    wa1_next = i_reg;
                    wd1_next = rd;
                    wa2_next = gpm1;
                    wd2_next = cur_reg;
                    i_next   = gpm1;
                    ret_next = bmmhq_pkg::S_SU_G;
                end
            end
            bmmhq_pkg::S_DONE: begin
                done = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        result.status = status_reg;
        result.hdl    = hdl_reg;
        result.ev     = ev_reg;
        result.evp    = evp_reg;
        result.evh    = evh_reg;
        result.cnt    = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmmhq_pkg::S_IDLE;
            count_reg <= 9'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        op_reg     <= op_next;
        inv_reg    <= inv_next;
        prio_reg   <= prio_next;
        pos_reg    <= pos_next;
        i_reg      <= i_next;
        bidx_reg   <= bidx_next;
        base_reg   <= base_next;
        wa1_reg    <= wa1_next;
        wa2_reg    <= wa2_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        best_reg   <= best_next;
        wd1_reg    <= wd1_next;
        wd2_reg    <= wd2_next;
        status_reg <= status_next;
        hdl_reg    <= hdl_next;
        ev_reg     <= ev_next;
        evp_reg    <= evp_next;
        evh_reg    <= evh_next;
    end

endmodule

@@ hw/rtl/bounded_min_max_heap_queue.sv @@
`timescale 1ns / 1ps
// A bad position goes straight to the result and a rejected push reads the root first.
// Each sift-down level does a child scan and a grandchild scan, with swaps through the
// single write port; each bubble-up step compares with the parent, then the grandparent.
// Throughput: one request at a time; the input is ready again once the result is
// registered, so a stalled result holds off the input. Reset clears the count, sets
// capacity_in_use to 256 and clears the handle valid bits at once; no clearing pass.
module bounded_min_max_heap_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // new_priority[31:0], heap_position[39:32]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // item_handle[7:0], evicted[8], evicted_priority[40:9],
                                   // evicted_handle[48:41], entry_count[57:49]
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    logic [8:0]          cap_reg;
    bmmhq_pkg::mem_req_t mem_req;
    bmmhq_pkg::entry_t   rd;
    bmmhq_pkg::result_t  result, out_reg;
    logic                done, out_free, m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) cap_reg <= bmmhq_pkg::CAP_RESET;
        else if (cfg_wr_en) cap_reg <= cfg_wr_data;
    end

    bmmhq_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd      (rd)
    );

    bmmhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_prio  (s_tdata[31:0]),
        .in_pos   (s_tdata[39:32]),
        .cap      (cap_reg),
        .rd       (rd),
        .mem_req  (mem_req),
        .out_free (out_free),
        .done     (done),
        .result   (result)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (done) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (done) out_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0, out_reg.cnt, out_reg.evh, out_reg.evp, out_reg.ev, out_reg.hdl};

endmodule

@@ hw/rtl/bmmhq_checker.sv @@
`timescale 1ns / 1ps
module bmmhq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[57:49] <= 9'd256)
        else $error("entry count above capacity");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == 2'd1 || m_tuser == 2'd3) |-> m_tdata[48:0] == 49'd0)
        else $error("rejected or bad request carries data");

    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tuser == 2'd0 && m_tdata[7:0] == m_tdata[48:41])
        else $error("eviction outside a push or handle not reused");

endmodule

bind bounded_min_max_heap_queue bmmhq_checker u_bmmhq_checker (.*);
